FILE: rtl/bmi_pkg.sv
// Package for the binary modular inverse block: item types and command codes.
// No dependencies.
package bmi_pkg;

   localparam logic [1:0] CMD_WR_MOD  = 2'd0;
   localparam logic [1:0] CMD_WR_ELEM = 2'd1;
   localparam logic [1:0] CMD_COMPUTE = 2'd2;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [3:0]  word_index;
      logic [31:0] word_value;
   } req_type;

   typedef struct packed {
      logic [31:0] result_word;
      logic [3:0]  result_index;
      logic        last_word;
   } rsp_type;

endpackage

FILE: rtl/binary_modular_inverse.sv
// Binary modular inverse, top level: word stores, bit-serial datapath, result output.
// Depends on bmi_pkg.
//
// Loads modulus m and element e a 32-bit word at a time (cmd 0 and 1; an index at or
// above NUM_WORDS is dropped). Compute (cmd 2) finds e^-1 mod odd m by the binary
// extended Euclid method over 2*L-1 iterations, L the bit length of m, and returns
// NUM_WORDS result items, least significant word first, last_word on the top one.
// All arithmetic is done one bit per cycle over W = NUM_WORDS*32 bits, apart
// from the swap step. A compute first scans m to find L, then per iteration does
// a serial compare, a pass for a - b and s1 - s2 (after a swap when the operands
// swap), a pass to add m back on a borrow and a pass for the halving add with a
// shifted alongside; then it outputs the NUM_WORDS result items. The input is
// stalled for the whole compute and output. Writes leave the block idle and ready
// for the next item. The walk across W bits of each word vector sets the rate.
module binary_modular_inverse #(
   parameter int NUM_WORDS = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  bmi_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output bmi_pkg::rsp_type rsp_data
);

   localparam int W  = NUM_WORDS * 32;
   localparam int BW = $clog2(W + 1);
   localparam int IW = BW + 1;
   localparam int WI = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_LEN  = 3'd1;
   localparam logic [2:0] ST_CMP  = 3'd2;
   localparam logic [2:0] ST_UPD  = 3'd3;
   localparam logic [2:0] ST_OUT  = 3'd4;

   logic [2:0]    state_ff;
   logic [W-1:0]  mod_ff, elem_ff;       // stores
   logic [W-1:0]  a_ff, b_ff, s1_ff, s2_ff, mr_ff;
   logic [BW-1:0] cnt_ff;
   logic [IW-1:0] iter_ff;
   logic          less_ff, odd_ff;
   logic          bor_a_ff, bor_s_ff, cy_ff, fix_ff;
   logic [WI-1:0] oidx_ff;
   logic          accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_data.result_word  = s2_ff[31:0];
   assign rsp_data.result_index = 4'(oidx_ff);
   assign rsp_data.last_word    = (oidx_ff == WI'(NUM_WORDS - 1));

   // serial bit of each operand
   logic xa, xb, x1, x2, xm;
   logic da, ds, nba, nbs, dd, nc;
   always_comb begin
      xa = a_ff[0];
      xb = b_ff[0];
      x1 = s1_ff[0];
      x2 = s2_ff[0];
      xm = mr_ff[0];
      // a - b
      da  = xa ^ xb ^ bor_a_ff;
      nba = (!xa & (xb | bor_a_ff)) | (xb & bor_a_ff);
      // s1 - s2
      ds  = x1 ^ x2 ^ bor_s_ff;
      nbs = (!x1 & (x2 | bor_s_ff)) | (x2 & bor_s_ff);
      // s1 + m when fix is set: borrow fix-up, then the halving add
      dd  = x1 ^ (xm & fix_ff) ^ cy_ff;
      nc  = (x1 & (xm & fix_ff)) | (cy_ff & (x1 ^ (xm & fix_ff)));
   end

   // Three passes per update:
   // pass P0 (in ST_UPD, phase 0): if a is odd, a-=b, s1-=s2 (raw), note borrow.
   // pass P1: s1 += m if borrow, note parity.  pass P2: s1 += m if odd, shift.
   logic [1:0] ph_ff;
   logic       par_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mod_ff <= '0; elem_ff <= '0;
         a_ff <= '0; b_ff <= '0; s1_ff <= '0; s2_ff <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  if (req_data.cmd == bmi_pkg::CMD_WR_MOD &&
                      32'(req_data.word_index) < NUM_WORDS)
                     mod_ff[req_data.word_index[WI-1:0]*32 +: 32] <= req_data.word_value;
                  if (req_data.cmd == bmi_pkg::CMD_WR_ELEM &&
                      32'(req_data.word_index) < NUM_WORDS)
                     elem_ff[req_data.word_index[WI-1:0]*32 +: 32] <= req_data.word_value;
                  if (req_data.cmd == bmi_pkg::CMD_COMPUTE) begin
                     state_ff <= ST_LEN;
                     mr_ff  <= mod_ff;
                     cnt_ff <= '0;
                     iter_ff <= '0;
                     a_ff <= elem_ff; b_ff <= mod_ff;
                     s1_ff <= W'(1); s2_ff <= '0;
                  end
               end
            end
            ST_LEN: begin
               // bit length: scan LSB up, remember 2*pos+1 at each set bit
               if (mr_ff[0]) iter_ff <= IW'(2 * cnt_ff + 1);
               mr_ff <= {mr_ff[0], mr_ff[W-1:1]};
               if (cnt_ff == BW'(W - 1)) begin
                  cnt_ff <= '0;
                  state_ff <= ST_CMP;
                  less_ff <= 1'b0;
                  odd_ff <= a_ff[0];
               end else cnt_ff <= cnt_ff + 1'b1;
            end
            ST_CMP: begin
               if (iter_ff == '0) begin
                  state_ff <= ST_OUT; oidx_ff <= '0;
               end else begin
                  // serial compare LSB first: higher bits override
                  if (a_ff[0] != b_ff[0]) less_ff <= b_ff[0];
                  a_ff <= {a_ff[0], a_ff[W-1:1]};
                  b_ff <= {b_ff[0], b_ff[W-1:1]};
                  if (cnt_ff == BW'(W - 1)) begin
                     cnt_ff <= '0; state_ff <= ST_UPD; ph_ff <= 2'd0;
                     bor_a_ff <= 1'b0; bor_s_ff <= 1'b0; cy_ff <= 1'b0;
                  end else cnt_ff <= cnt_ff + 1'b1;
               end
            end
            ST_UPD: begin
               unique case (ph_ff)
                  2'd0: begin
                     if (cnt_ff == '0 && odd_ff && less_ff) begin
                        // swap first (m held still), then start
                        a_ff <= b_ff; b_ff <= a_ff; s1_ff <= s2_ff; s2_ff <= s1_ff;
                        less_ff <= 1'b0;
                     end else begin
                        mr_ff <= {mr_ff[0], mr_ff[W-1:1]};
                        a_ff  <= {odd_ff ? da : xa, a_ff[W-1:1]};
                        b_ff  <= {b_ff[0], b_ff[W-1:1]};
                        s1_ff <= {odd_ff ? ds : x1, s1_ff[W-1:1]};
                        s2_ff <= {s2_ff[0], s2_ff[W-1:1]};
                        bor_a_ff <= nba; bor_s_ff <= nbs;
                        if (cnt_ff == BW'(W - 1)) begin
                           cnt_ff <= '0; ph_ff <= 2'd1;
                           fix_ff <= odd_ff && nbs; cy_ff <= 1'b0;
                        end else cnt_ff <= cnt_ff + 1'b1;
                     end
                  end
                  2'd1: begin
                     mr_ff <= {mr_ff[0], mr_ff[W-1:1]};
                     s1_ff <= {dd, s1_ff[W-1:1]};
                     cy_ff <= nc;
                     if (cnt_ff == '0) par_ff <= dd;
                     if (cnt_ff == BW'(W - 1)) begin
                        cnt_ff <= '0; ph_ff <= 2'd2;
                        fix_ff <= (cnt_ff == '0) ? dd : par_ff; cy_ff <= 1'b0;
                     end else cnt_ff <= cnt_ff + 1'b1;
                  end
                  default: begin
                     // s1 + m (if odd), then shift right with carry on top;
                     // a shifted right in the same pass
                     mr_ff <= {mr_ff[0], mr_ff[W-1:1]};
                     s1_ff <= {dd, s1_ff[W-1:1]};
                     cy_ff <= nc;
                     a_ff  <= {a_ff[0], a_ff[W-1:1]};
                     if (cnt_ff == BW'(W - 1)) begin
                        s1_ff <= {nc, dd, s1_ff[W-1:2]};
                        a_ff  <= {1'b0, a_ff[0], a_ff[W-1:2]};
                        cnt_ff <= '0; state_ff <= ST_CMP;
                        iter_ff <= iter_ff - 1'b1;
                        less_ff <= 1'b0;
                        odd_ff <= a_ff[2 % W];
                     end else cnt_ff <= cnt_ff + 1'b1;
                  end
               endcase
            end
            ST_OUT: begin
               if (!rsp_stall) begin
                  s2_ff <= {s2_ff[31:0], s2_ff[W-1:32]};
                  oidx_ff <= oidx_ff + 1'b1;
                  if (oidx_ff == WI'(NUM_WORDS - 1)) state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

FILE: tb/sv/tb_binary_modular_inverse.sv
`timescale 1ns / 1ps
// Self-checking testbench for binary_modular_inverse: directed table, then random
// load/compute sequences under varying idle and stall pressure. Depends on bmi_pkg.
module tb_binary_modular_inverse;

   localparam int NW              = 8;
   localparam int WB              = NW * 32;
   localparam int ITEM_TARGET     = 140;
   localparam int CYCLE_LIMIT     = 40000000;
   localparam int TAIL_CYCLES     = 400;
   localparam int HOLD_OFF_CYCLES = 200000;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   logic             clock, reset;
   logic             req_valid, req_stall;
   bmi_pkg::req_type req_data;
   logic             rsp_valid, rsp_stall;
   bmi_pkg::rsp_type rsp_data;

   binary_modular_inverse #(.NUM_WORDS(NW)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   // predictor's own copy of the loaded operands
   logic [31:0]      mod_words [NW];
   logic [31:0]      elem_words [NW];
   bmi_pkg::rsp_type inverse_words_due [$];

   int  send_idle_pct, recv_stall_pct, hold_off_left;
   int  fail_count, predict_fail_count, cycle_count;
   int  items_sent, computes_done, words_checked;
   bit  test_done, hold_off_req, hold_off_seen;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Binary extended Euclid over WB bits, same wrap and halving carry as the block.
   function automatic logic [WB-1:0] inverse_of(logic [WB-1:0] m, logic [WB-1:0] e);
      int          len, iters;
      logic [WB-1:0] a, b, s1, s2, t;
      logic [WB:0]   sum;
      len = 0;
      for (int i = 0; i < WB; i++) if (m[i]) len = i + 1;
      iters = (len == 0) ? 0 : 2 * len - 1;
      a = e; b = m; s1 = WB'(1); s2 = '0;
      for (int it = 0; it < iters; it++) begin
         if (a[0]) begin
            if (a < b) begin
               t = a; a = b; b = t;
               t = s1; s1 = s2; s2 = t;
            end
            a = a - b;
            if (s1 < s2) s1 = s1 - s2 + m;   // borrow: add m back
            else s1 = s1 - s2;
         end
         a = a >> 1;
         sum = s1[0] ? {1'b0, s1} + {1'b0, m} : {1'b0, s1};
         s1 = sum[WB:1];
      end
      return s2;
   endfunction

   function automatic logic [WB-1:0] join_words(logic [31:0] w [NW]);
      logic [WB-1:0] v;
      for (int i = 0; i < NW; i++) v[i*32 +: 32] = w[i];
      return v;
   endfunction

   // Update the operand copy for an accepted item; queue the inverse words of a compute.
   function automatic logic [WB-1:0] track_item(bmi_pkg::req_type it);
      logic [WB-1:0]    inv;
      bmi_pkg::rsp_type r;
      inv = '0;
      case (it.cmd)
         bmi_pkg::CMD_WR_MOD:
            if (it.word_index < NW) mod_words[it.word_index] = it.word_value;
         bmi_pkg::CMD_WR_ELEM:
            if (it.word_index < NW) elem_words[it.word_index] = it.word_value;
         bmi_pkg::CMD_COMPUTE: begin
            inv = inverse_of(join_words(mod_words), join_words(elem_words));
            for (int k = 0; k < NW; k++) begin
               r.result_word  = inv[k*32 +: 32];
               r.result_index = 4'(k);
               r.last_word    = (k == NW - 1);
               inverse_words_due.push_back(r);
            end
            computes_done++;
         end
         default: ;
      endcase
      return inv;
   endfunction

   // Offer one item; valid only drops when an idle gap is taken.
   task automatic send_item(bmi_pkg::req_type it, output logic [WB-1:0] inv);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (req_stall);
      inv = track_item(it);
      items_sent++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (inverse_words_due.size() != 0) @(posedge clock);
   endtask

   function automatic bmi_pkg::req_type make_item(logic [1:0] c, int idx, logic [31:0] v);
      bmi_pkg::req_type it;
      it.cmd = c; it.word_index = 4'(idx); it.word_value = v;
      return it;
   endfunction

   // result side: check against the oldest expected word, then pick next stall
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (inverse_words_due.size() == 0) begin
               $error("unexpected result item: word %h index %0d",
                      rsp_data.result_word, rsp_data.result_index);
               fail_count++;
            end else begin
               automatic bmi_pkg::rsp_type want = inverse_words_due.pop_front();
               if (rsp_data.result_word !== want.result_word) begin
                  $error("result_word: expected %h, got %h",
                         want.result_word, rsp_data.result_word);
                  fail_count++;
               end
               if (rsp_data.result_index !== want.result_index) begin
                  $error("result_index: expected %0d, got %0d",
                         want.result_index, rsp_data.result_index);
                  fail_count++;
               end
               if (rsp_data.last_word !== want.last_word) begin
                  $error("last_word: expected %0d, got %0d",
                         want.last_word, rsp_data.last_word);
                  fail_count++;
               end
               words_checked++;
            end
         end
      end
      // long hold-off is counted here once requested
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_off_req && !hold_off_seen) begin
         hold_off_seen <= 1'b1;
         hold_off_left <= HOLD_OFF_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else if (hold_off_left > 0) begin
         rsp_stall <= 1'b1;
         hold_off_left <= hold_off_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!test_done && cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   typedef struct {
      bmi_pkg::req_type it;
      bit               chk;      // typed-in low word of the inverse to cross-check
      logic [31:0]      inv0;
   } directed_row_type;

   directed_row_type directed_rows [$];

   task automatic add_row(logic [1:0] c, int idx, logic [31:0] v,
                          bit chk = 0, logic [31:0] inv0 = '0);
      directed_row_type r;
      r.it = make_item(c, idx, v); r.chk = chk; r.inv0 = inv0;
      directed_rows.push_back(r);
   endtask

   // One load/compute sequence, at times with a noise item, with a mostly small modulus.
   task automatic random_sequence();
      logic [31:0]   want_mod [NW];
      logic [WB-1:0] inv;
      int            bits, top;
      for (int i = 0; i < NW; i++) want_mod[i] = '0;
      bits = $urandom_range(24, 2);
      want_mod[0] = $urandom & ((bits == 32) ? 32'hFFFF_FFFF : ((32'd1 << bits) - 1));
      want_mod[0][bits-1] = 1'b1;
      if ($urandom_range(9) != 0) want_mod[0][0] = 1'b1;   // mostly odd
      if ($urandom_range(11) == 0) begin
         want_mod[0] = $urandom | 32'd1;
         want_mod[1] = $urandom_range(255, 1);
      end
      if ($urandom_range(30) == 0) want_mod[0] = '0;        // zero modulus
      for (int i = 0; i < NW; i++)
         if (mod_words[i] !== want_mod[i])
            send_item(make_item(bmi_pkg::CMD_WR_MOD, i, want_mod[i]), inv);
      top = ($urandom_range(3) == 0) ? $urandom_range(NW - 1) : 0;
      for (int i = 0; i <= top; i++)
         send_item(make_item(bmi_pkg::CMD_WR_ELEM, i,
                   ($urandom_range(15) == 0) ? 32'd0 : $urandom), inv);
      if ($urandom_range(99) < 20) begin
         // noise: out-of-range writes or the unused command
         case ($urandom_range(2))
            0: send_item(make_item(bmi_pkg::CMD_WR_MOD, $urandom_range(15, NW),
                                   $urandom), inv);
            1: send_item(make_item(bmi_pkg::CMD_WR_ELEM, $urandom_range(15, NW),
                                   $urandom), inv);
            default: send_item(make_item(CMD_UNUSED, $urandom_range(15), $urandom), inv);
         endcase
      end
      send_item(make_item(bmi_pkg::CMD_COMPUTE, $urandom_range(15), $urandom), inv);
   endtask

   initial begin
      logic [WB-1:0] inv;
      reset = 1'b1; req_valid = 1'b0; req_data = '0;
      send_idle_pct = 0; recv_stall_pct = 0;
      items_sent = 0; computes_done = 0; test_done = 0;
      for (int i = 0; i < NW; i++) begin mod_words[i] = '0; elem_words[i] = '0; end
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: after reset, small known inverse, zero element, ignored items,
      // a full-width modulus, even modulus, element above m, zero modulus
      add_row(bmi_pkg::CMD_COMPUTE, 0, 32'h0, 1, 32'd0);
      add_row(bmi_pkg::CMD_WR_MOD, 0, 32'd7);
      add_row(bmi_pkg::CMD_WR_ELEM, 0, 32'd3);
      add_row(bmi_pkg::CMD_COMPUTE, 15, 32'hFFFF_FFFF, 1, 32'd5);
      add_row(bmi_pkg::CMD_WR_ELEM, 0, 32'd0);
      add_row(bmi_pkg::CMD_COMPUTE, 0, 32'h0, 1, 32'd0);
      add_row(bmi_pkg::CMD_WR_ELEM, 15, 32'hFFFF_FFFF);
      add_row(bmi_pkg::CMD_WR_MOD, 8, 32'hFFFF_FFFF);
      add_row(CMD_UNUSED, 15, 32'hFFFF_FFFF);
      add_row(bmi_pkg::CMD_WR_ELEM, 0, 32'd3);
      add_row(bmi_pkg::CMD_COMPUTE, 0, 32'h0, 1, 32'd5);
      add_row(bmi_pkg::CMD_WR_MOD, 7, 32'hFFFF_FFFF);
      add_row(bmi_pkg::CMD_WR_ELEM, 7, 32'h8000_0001);
      add_row(bmi_pkg::CMD_COMPUTE, 0, 32'h0);
      add_row(bmi_pkg::CMD_WR_MOD, 7, 32'h0);
      add_row(bmi_pkg::CMD_WR_ELEM, 7, 32'h0);
      add_row(bmi_pkg::CMD_WR_MOD, 0, 32'd8);
      add_row(bmi_pkg::CMD_COMPUTE, 0, 32'h0);
      add_row(bmi_pkg::CMD_WR_MOD, 0, 32'd11);
      add_row(bmi_pkg::CMD_WR_ELEM, 0, 32'hFFFF_FFFF);
      add_row(bmi_pkg::CMD_COMPUTE, 0, 32'h0);
      add_row(bmi_pkg::CMD_WR_MOD, 0, 32'd0);
      add_row(bmi_pkg::CMD_COMPUTE, 0, 32'h0, 1, 32'd0);
      foreach (directed_rows[i]) begin
         send_item(directed_rows[i].it, inv);
         if (directed_rows[i].chk && inv[31:0] !== directed_rows[i].inv0) begin
            $error("predicted result_word: expected %h, got %h",
                   directed_rows[i].inv0, inv[31:0]);
            predict_fail_count++;
         end
      end
      drain_results();

      // random phases; the first starts with a long receiver hold-off
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  hold_off_req = 1; end
            1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
            default: begin send_idle_pct = 35; recv_stall_pct = 35; end
         endcase
         while (items_sent < directed_rows.size() +
                (ph + 1) * (ITEM_TARGET - directed_rows.size()) / 4)
            random_sequence();
         drain_results();   // sender waits for every expected item
      end

      req_valid <= 1'b0;
      repeat (TAIL_CYCLES) @(posedge clock);
      test_done = 1;
      $display("covered %0d request items, %0d inverses, %0d result words checked",
               items_sent, computes_done, words_checked);
      if (fail_count == 0 && predict_fail_count == 0 &&
          inverse_words_due.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         if (inverse_words_due.size() != 0)
            $error("%0d result items never arrived", inverse_words_due.size());
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
